[rtl/sle_pkg.sv]
package sle_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef enum logic [3:0] {
      OP_INS_FRONT  = 4'd0,
      OP_INS_AT     = 4'd1,
      OP_INS_BACK   = 4'd2,
      OP_INS_SORTED = 4'd3,
      OP_DEL_FRONT  = 4'd4,
      OP_DEL_AT     = 4'd5,
      OP_DEL_BACK   = 4'd6,
      OP_DEL_VALUE  = 4'd7,
      OP_READ_AT    = 4'd8,
      OP_FIND       = 4'd9
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_EMPTY     = 3'd2,
      STAT_BAD_POS   = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE,
      ST_APPLY
   } state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                     scan;
      logic                     apply;
      logic                     ins;
      logic                     del;
      logic [IDX_W-1:0]         target;
      logic [CNT_W-1:0]         count;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

   // per-cell compare results
   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flag_type;

   // index of the lowest set bit, zero when none
   function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/sle_cell.sv]
module sle_cell
   import sle_pkg::*;
(
   input  logic                     clock,
   input  logic [IDX_W-1:0]         cell_index,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] left_entry,
   input  logic signed [DATA_W-1:0] right_entry,
   output logic signed [DATA_W-1:0] entry,
   output cell_flag_type            flags
);

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   cell_flag_type            flags_ff, flags_in;
   logic                     valid;

   assign valid = CNT_W'(cell_index) < ctrl.count;

   // compare against the broadcast value
   always_comb begin
      flags_in = flags_ff;
      if (ctrl.scan) begin
         flags_in.lt = valid && (entry_ff < ctrl.value);
         flags_in.eq = valid && (entry_ff == ctrl.value);
      end
   end

   // shift one place back on insert, one place forward on delete
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.apply) begin
         if (ctrl.ins) begin
            if (cell_index == ctrl.target) begin
               entry_in = ctrl.value;
            end else if (cell_index > ctrl.target) begin
               entry_in = left_entry;
            end
         end else if (ctrl.del) begin
            if (cell_index >= ctrl.target) begin
               entry_in = right_entry;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

[rtl/sequential_list_engine.sv]
// ordered list of up to 16 signed 32-bit values held in a row of cells, one
// entry per cell. a transaction is taken when start is high and busy is low;
// busy then stays high through the scan, resolve and apply states, and the
// response appears on the rsp_ ports for exactly one cycle marked by
// rsp_strobe, in the apply state, and is taken at the edge that ends it. the
// response cannot be held off, so capture it on the strobe. a new transaction
// is not taken until the last one is through; the sequencer steps are: accept,
// every cell compares its entry with the request value, pick the target
// position and status, and all cells shift in parallel. entries beyond the
// count hold stale data and are never reported.
module sequential_list_engine
   import sle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_op,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_data_out,
   output logic [3:0]         rsp_found_position,
   output logic [4:0]         rsp_count_out
);

   state_type state_ff, state_in;

   // latched request
   logic [3:0]               op_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [4:0]               pos_ff;

   // list length
   logic [CNT_W-1:0] count_ff, count_in;

   // resolved outcome
   status_type               res_status_ff, res_status_in;
   logic [IDX_W-1:0]         res_pos_ff, res_pos_in;
   logic signed [DATA_W-1:0] res_data_ff, res_data_in;
   logic [CNT_W-1:0]         res_count_ff, res_count_in;
   logic                     res_ins_ff, res_ins_in;
   logic                     res_del_ff, res_del_in;

   // sequencer strobes
   logic accept, do_scan, do_resolve, do_apply;

   // cell row
   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] cell_entry [CAPACITY];
   cell_flag_type            cell_flags [CAPACITY];
   logic [CAPACITY-1:0]      lt_vec, eq_vec;

   // ---------------------------------------------------------------- fsm
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (start) state_in = ST_SCAN;
         ST_SCAN:    state_in = ST_RESOLVE;
         ST_RESOLVE: state_in = ST_APPLY;
         ST_APPLY:   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      do_scan    = 1'b0;
      do_resolve = 1'b0;
      do_apply   = 1'b0;
      unique case (state_ff)
         ST_IDLE:    busy       = 1'b0;
         ST_SCAN:    do_scan    = 1'b1;
         ST_RESOLVE: do_resolve = 1'b1;
         ST_APPLY:   do_apply   = 1'b1;
         default:    busy       = 1'b1;
      endcase
   end

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // request capture, payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   // ---------------------------------------------------------- cell row
   assign ctrl.scan   = do_scan;
   assign ctrl.apply  = do_apply;
   assign ctrl.ins    = res_ins_ff;
   assign ctrl.del    = res_del_ff;
   assign ctrl.target = res_pos_ff;
   assign ctrl.count  = count_ff;
   assign ctrl.value  = value_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry, right_entry;

      // on insert the front cell gets new data only from the broadcast value
      if (i == 0) begin : g_front
         assign left_entry = '0;
      end else begin : g_mid_l
         assign left_entry = cell_entry[i-1];
      end

      // the back cell has nothing behind it
      if (i == CAPACITY - 1) begin : g_back
         assign right_entry = '0;
      end else begin : g_mid_r
         assign right_entry = cell_entry[i+1];
      end

      sle_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(i)),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .flags       (cell_flags[i])
      );

      assign lt_vec[i] = cell_flags[i].lt;
      assign eq_vec[i] = cell_flags[i].eq;
   end

   // ------------------------------------------------------------ resolve
   // compare flags are masked by the count, so the first clear lt bit is
   // the sorted insert point and the first set eq bit is the first match
   always_comb begin
      logic             full, empty;
      logic [CNT_W-1:0] count_dec;
      logic [IDX_W-1:0] sort_pos, match_pos;
      logic             any_match;

      full      = count_ff == CNT_W'(CAPACITY);
      empty     = count_ff == '0;
      count_dec = count_ff - CNT_W'(1);
      sort_pos  = first_set(~lt_vec);
      match_pos = first_set(eq_vec);
      any_match = |eq_vec;

      res_status_in = STAT_OK;
      res_pos_in    = '0;
      res_ins_in    = 1'b0;
      res_del_in    = 1'b0;

      unique case (op_type'(op_ff))
         OP_INS_FRONT, OP_INS_AT, OP_INS_BACK, OP_INS_SORTED: begin
            if (full) begin
               res_status_in = STAT_FULL;
            end else if (op_type'(op_ff) == OP_INS_AT && CNT_W'(pos_ff) > count_ff) begin
               res_status_in = STAT_BAD_POS;
            end else begin
               res_ins_in = 1'b1;
               case (op_type'(op_ff))
                  OP_INS_AT:     res_pos_in = pos_ff[IDX_W-1:0];
                  OP_INS_BACK:   res_pos_in = count_ff[IDX_W-1:0];
                  OP_INS_SORTED: res_pos_in = sort_pos;
                  default:       res_pos_in = '0;
               endcase
            end
         end
         OP_DEL_FRONT, OP_DEL_AT, OP_DEL_BACK, OP_READ_AT: begin
            if (empty) begin
               res_status_in = STAT_EMPTY;
            end else if ((op_type'(op_ff) == OP_DEL_AT || op_type'(op_ff) == OP_READ_AT)
                         && CNT_W'(pos_ff) >= count_ff) begin
               res_status_in = STAT_BAD_POS;
            end else begin
               res_del_in = op_type'(op_ff) != OP_READ_AT;
               case (op_type'(op_ff))
                  OP_DEL_BACK: res_pos_in = count_dec[IDX_W-1:0];
                  OP_DEL_AT,
                  OP_READ_AT:  res_pos_in = pos_ff[IDX_W-1:0];
                  default:     res_pos_in = '0;
               endcase
            end
         end
         OP_DEL_VALUE, OP_FIND: begin
            if (empty) begin
               res_status_in = STAT_EMPTY;
            end else if (!any_match) begin
               res_status_in = STAT_NOT_FOUND;
            end else begin
               res_pos_in = match_pos;
               res_del_in = op_type'(op_ff) == OP_DEL_VALUE;
            end
         end
         default: res_status_in = STAT_BAD_POS;
      endcase

      // read data only for a successful read
      res_data_in = '0;
      if (op_type'(op_ff) == OP_READ_AT && res_status_in == STAT_OK) begin
         res_data_in = cell_entry[res_pos_in];
      end

      res_count_in = count_ff;
      if (res_ins_in) begin
         res_count_in = count_ff + CNT_W'(1);
      end else if (res_del_in) begin
         res_count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ins_ff <= 1'b0;
         res_del_ff <= 1'b0;
      end else if (do_resolve) begin
         res_ins_ff <= res_ins_in;
         res_del_ff <= res_del_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_resolve) begin
         res_status_ff <= res_status_in;
         res_pos_ff    <= res_pos_in;
         res_data_ff   <= res_data_in;
         res_count_ff  <= res_count_in;
      end
   end

   // count moves with the shift
   assign count_in = do_apply ? res_count_ff : count_ff;

   // ----------------------------------------------------------- response
   assign rsp_strobe         = do_apply;
   assign rsp_ok             = res_status_ff == STAT_OK;
   assign rsp_status         = res_status_ff;
   assign rsp_data_out       = res_data_ff;
   assign rsp_found_position = (res_status_ff == STAT_OK) ? res_pos_ff : '0;
   assign rsp_count_out      = res_count_ff;

endmodule
